### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by the checker file nbt_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, muted while aresetn is low.
`define NBT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on aclk, muted while aresetn is low.
`define NBT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

### sv/nbt_pkg.sv
// ----------------------------------------------------------------------------
// nbt_pkg
// Shared types, codes and constants of the neighbor table.
// ----------------------------------------------------------------------------
package nbt_pkg;

    localparam int unsigned CAPACITY_DEF = 16;
    localparam logic [31:0] TIMEOUT_RESET = 32'd3000;

    // input commands
    localparam logic [1:0] CMD_HELLO = 2'd0;
    localparam logic [1:0] CMD_SWEEP = 2'd1;
    localparam logic [1:0] CMD_LIST  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_REFRESHED = 2'd0;
    localparam logic [1:0] STATUS_ADDED     = 2'd1;
    localparam logic [1:0] STATUS_EVICTED   = 2'd2;
    localparam logic [1:0] STATUS_SUMMARY   = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] address;
        logic [31:0] now;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] neighbor_address;
        logic        entry_valid;
        logic [6:0]  removed_count;
        logic        last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_HELLO,
        ST_SWEEP,
        ST_LIST,
        ST_SUMMARY
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;          // latch item, arm pass counter
        logic search;        // compare address against table
        logic hello_wr;      // remove/evict, append, emit hello result
        logic rotate;        // pop head, re-append if kept
        logic list_mode;     // rotate keeps every entry and emits it
        logic emit_summary;  // emit sweep or empty-list result
    } ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic rem_zero;
        logic rem_one;
        logic out_free;
    } stat_t;

endpackage

### sv/nbt_ctrl.sv
// ----------------------------------------------------------------------------
// nbt_ctrl
// Command sequencer: picks the pass for each item and paces it on the
// result slot.
// ----------------------------------------------------------------------------
module nbt_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic [1:0]      s_cmd,
    input  nbt_pkg::stat_t  stat,
    output nbt_pkg::ctrl_t  ctrl,
    output logic            s_ready
);

    nbt_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nbt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            nbt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_cmd)
                        nbt_pkg::CMD_HELLO: state_next = nbt_pkg::ST_SEARCH;
                        nbt_pkg::CMD_SWEEP: state_next = nbt_pkg::ST_SWEEP;
                        nbt_pkg::CMD_LIST:  state_next = nbt_pkg::ST_LIST;
                        default:            state_next = nbt_pkg::ST_IDLE;
                    endcase
                end
            end
            nbt_pkg::ST_SEARCH: state_next = nbt_pkg::ST_HELLO;
            nbt_pkg::ST_HELLO: begin
                if (stat.out_free) state_next = nbt_pkg::ST_IDLE;
            end
            nbt_pkg::ST_SWEEP: begin
                if (stat.rem_zero) state_next = nbt_pkg::ST_SUMMARY;
            end
            nbt_pkg::ST_LIST: begin
                if (stat.rem_zero) begin
                    state_next = nbt_pkg::ST_SUMMARY;
                end else if (stat.out_free && stat.rem_one) begin
                    state_next = nbt_pkg::ST_IDLE;
                end
            end
            nbt_pkg::ST_SUMMARY: begin
                if (stat.out_free) state_next = nbt_pkg::ST_IDLE;
            end
            default: state_next = nbt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl    = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            nbt_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                ctrl.load = s_valid;
            end
            nbt_pkg::ST_SEARCH: ctrl.search = 1'b1;
            nbt_pkg::ST_HELLO:  ctrl.hello_wr = stat.out_free;
            nbt_pkg::ST_SWEEP:  ctrl.rotate = !stat.rem_zero;
            nbt_pkg::ST_LIST: begin
                ctrl.rotate    = !stat.rem_zero && stat.out_free;
                ctrl.list_mode = 1'b1;
            end
            nbt_pkg::ST_SUMMARY: ctrl.emit_summary = stat.out_free;
            default: ctrl = '0;
        endcase
    end

endmodule

### sv/nbt_datapath.sv
// ----------------------------------------------------------------------------
// nbt_datapath
// Neighbor table storage, address compare, head aging test and result
// register.
// ----------------------------------------------------------------------------
module nbt_datapath #(
    parameter int unsigned CAPACITY = nbt_pkg::CAPACITY_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  nbt_pkg::in_item_t   s_data,
    input  logic                cfg_wr_en,
    input  logic [31:0]         cfg_wr_data,
    input  logic                m_ready,
    input  nbt_pkg::ctrl_t      ctrl,
    output nbt_pkg::stat_t      stat,
    output logic                m_valid,
    output nbt_pkg::out_item_t  m_data
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned IW = $clog2(CAPACITY);

    logic [31:0]        ent_addr_reg [CAPACITY];
    logic [31:0]        ent_seen_reg [CAPACITY];
    logic [31:0]        ent_addr_next [CAPACITY];
    logic [31:0]        ent_seen_next [CAPACITY];
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      rem_reg, rem_next;
    logic [CW-1:0]      removed_reg, removed_next;
    logic [31:0]        timeout_reg;
    nbt_pkg::in_item_t  item_reg;
    logic               found_reg;
    logic [IW-1:0]      idx_reg;
    logic               out_valid_reg, out_valid_next;
    nbt_pkg::out_item_t out_reg, out_next;

    logic [CAPACITY-1:0] match;
    logic [CAPACITY-1:0] first;
    logic [IW-1:0]       first_idx;
    logic                full;
    logic                rm_valid;
    logic [CW-1:0]       rm_idx;
    logic [CW-1:0]       tail;
    logic [31:0]         elapsed;
    logic                keep;
    logic [1:0]          hello_status;

    assign full = (count_reg == CW'(CAPACITY));

    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            match[k] = (CW'(k) < count_reg) && (ent_addr_reg[k] == item_reg.address);
        end
    end

    assign first = match & (~match + 1'b1);

    always_comb begin
        first_idx = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (first[k]) first_idx = first_idx | IW'(k);
        end
    end

    assign rm_valid = found_reg || full;
    assign rm_idx   = found_reg ? CW'(idx_reg) : '0;
    assign tail     = rm_valid ? count_reg - 1'b1 : count_reg;

    assign elapsed = item_reg.now - ent_seen_reg[0];
    assign keep    = ctrl.list_mode || (elapsed < timeout_reg);

    always_comb begin
        if (found_reg) begin
            hello_status = nbt_pkg::STATUS_REFRESHED;
        end else if (full) begin
            hello_status = nbt_pkg::STATUS_EVICTED;
        end else begin
            hello_status = nbt_pkg::STATUS_ADDED;
        end
    end

    // table update: hello removes and appends, rotate pops the head
    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            ent_addr_next[k] = ent_addr_reg[k];
            ent_seen_next[k] = ent_seen_reg[k];
        end
        count_next = count_reg;
        if (ctrl.hello_wr) begin
            for (int k = 0; k < CAPACITY - 1; k++) begin
                if (rm_valid && CW'(k) >= rm_idx) begin
                    ent_addr_next[k] = ent_addr_reg[k + 1];
                    ent_seen_next[k] = ent_seen_reg[k + 1];
                end
            end
            for (int k = 0; k < CAPACITY; k++) begin
                if (CW'(k) == tail) begin
                    ent_addr_next[k] = item_reg.address;
                    ent_seen_next[k] = item_reg.now;
                end
            end
            count_next = tail + 1'b1;
        end else if (ctrl.rotate) begin
            for (int k = 0; k < CAPACITY - 1; k++) begin
                ent_addr_next[k] = ent_addr_reg[k + 1];
                ent_seen_next[k] = ent_seen_reg[k + 1];
            end
            for (int k = 0; k < CAPACITY; k++) begin
                if (keep && CW'(k) == count_reg - 1'b1) begin
                    ent_addr_next[k] = ent_addr_reg[0];
                    ent_seen_next[k] = ent_seen_reg[0];
                end
            end
            if (!keep) count_next = count_reg - 1'b1;
        end
    end

    always_comb begin
        rem_next     = rem_reg;
        removed_next = removed_reg;
        if (ctrl.load) begin
            rem_next     = count_reg;
            removed_next = '0;
        end else if (ctrl.rotate) begin
            rem_next = rem_reg - 1'b1;
            if (!keep) removed_next = removed_reg + 1'b1;
        end
    end

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (ctrl.hello_wr) begin
            out_valid_next = 1'b1;
            out_next       = '{status: hello_status, neighbor_address: '0,
                               entry_valid: 1'b0, removed_count: '0, last: 1'b1};
        end else if (ctrl.rotate && ctrl.list_mode) begin
            out_valid_next = 1'b1;
            out_next       = '{status: nbt_pkg::STATUS_SUMMARY,
                               neighbor_address: ent_addr_reg[0], entry_valid: 1'b1,
                               removed_count: '0, last: (rem_reg == CW'(1))};
        end else if (ctrl.emit_summary) begin
            out_valid_next = 1'b1;
            out_next       = '{status: nbt_pkg::STATUS_SUMMARY, neighbor_address: '0,
                               entry_valid: 1'b0, removed_count: 7'(removed_reg),
                               last: 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
            timeout_reg   <= nbt_pkg::TIMEOUT_RESET;
        end else begin
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) timeout_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < CAPACITY; k++) begin
            ent_addr_reg[k] <= ent_addr_next[k];
            ent_seen_reg[k] <= ent_seen_next[k];
        end
        removed_reg <= removed_next;
        out_reg     <= out_next;
        if (ctrl.load) item_reg <= s_data;
        if (ctrl.search) begin
            found_reg <= |match;
            idx_reg   <= first_idx;
        end
    end

    assign stat.rem_zero = (rem_reg == '0);
    assign stat.rem_one  = (rem_reg == CW'(1));
    assign stat.out_free = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

### sv/neighbor_table_with_aging_unit.sv
// ----------------------------------------------------------------------------
// neighbor_table_with_aging_unit
// Ordered neighbor table, oldest first, with hello refresh, timeout sweep
// and in-order listing.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                     Beat
//  -------  ------------------------  -------------------------------------
//  input    s_valid s_ready s_data    one command: hello, sweep or list
//  result   m_valid m_ready m_data    one result; a list gives one per entry
//  config   cfg_wr_en cfg_wr_data     timeout_ticks, taken on the same edge
//
//  One item at a time. Hello: accept, parallel address compare, then
//  shift-and-append. Sweep: one entry aged per cycle by rotating the
//  table head through a single subtract/compare, then a move to the
//  summary state, which emits the summary. List: one entry per cycle
//  from the table head while the result slot is free; an empty table goes straight to the summary state.
//  Result register decouples the sides; a stalled m_ready holds a hello, list or summary, not a sweep.
//  Reset empties the table at once; no clearing pass. Command code 3 drops.
//
module neighbor_table_with_aging_unit #(
    parameter int unsigned CAPACITY = nbt_pkg::CAPACITY_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  nbt_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output nbt_pkg::out_item_t  m_data,
    input  logic                cfg_wr_en,
    input  logic [31:0]         cfg_wr_data
);

    // command and status between sequencer and table
    nbt_pkg::ctrl_t ctrl;
    nbt_pkg::stat_t stat;

    // sequencer: one pass per item, paced on the result slot
    nbt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_data.cmd),
        .stat    (stat),
        .ctrl    (ctrl),
        .s_ready (s_ready)
    );

    // table, compare, aging test and result register
    nbt_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_ready     (m_ready),
        .ctrl        (ctrl),
        .stat        (stat),
        .m_valid     (m_valid),
        .m_data      (m_data)
    );

endmodule

### sv/nbt_checker.sv
// ----------------------------------------------------------------------------
// nbt_checker
// Port-level checks of the neighbor table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nbt_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input nbt_pkg::in_item_t   s_data,
    input logic                m_valid,
    input logic                m_ready,
    input nbt_pkg::out_item_t  m_data
);

    logic stalled;
    logic entry_beat;
    logic entry_ok;
    logic hello_beat;
    logic hello_ok;
    logic cmd_taken;

    assign stalled    = m_valid && !m_ready;
    assign entry_beat = m_valid && m_data.entry_valid;
    assign entry_ok   = (m_data.status == nbt_pkg::STATUS_SUMMARY) &&
                        (m_data.removed_count == 7'd0);
    assign hello_beat = m_valid && (m_data.status != nbt_pkg::STATUS_SUMMARY);
    assign hello_ok   = m_data.last && !m_data.entry_valid &&
                        (m_data.removed_count == 7'd0);
    assign cmd_taken  = s_valid && s_ready && (s_data.cmd != nbt_pkg::CMD_NONE);

    `NBT_ASSERT_NXT(a_m_hold, stalled, m_valid, "result beat dropped while stalled")
    `NBT_ASSERT_NXT(a_m_stable, stalled, $stable(m_data), "result beat changed while stalled")
    `NBT_ASSERT_IMP(a_entry_is_list, entry_beat, entry_ok, "listed entry with wrong status")
    `NBT_ASSERT_IMP(a_hello_single, hello_beat, hello_ok, "hello result malformed")
    `NBT_ASSERT_NXT(a_busy_after_cmd, cmd_taken, !s_ready, "new beat taken during a pass")

endmodule

bind neighbor_table_with_aging_unit nbt_checker u_nbt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
